[hw/rtl/rtar_pkg.sv]
// Shared types and constants of the RGB to ASCII ramp decimator.
`default_nettype none

package rtar_pkg;

  localparam int CfgWidth  = 13;
  localparam int IdxWidth  = 2;
  localparam int LumaWidth = 24;
  localparam int RampChars = 10;

  localparam logic [IdxWidth-1:0] RegSrcWidth  = 2'd0;
  localparam logic [IdxWidth-1:0] RegSrcHeight = 2'd1;
  localparam logic [IdxWidth-1:0] RegOutWidth  = 2'd2;
  localparam logic [IdxWidth-1:0] RegOutHeight = 2'd3;

  localparam logic [CfgWidth-1:0] SrcWidthReset  = 13'd640;
  localparam logic [CfgWidth-1:0] SrcHeightReset = 13'd480;
  localparam logic [CfgWidth-1:0] OutWidthReset  = 13'd80;
  localparam logic [CfgWidth-1:0] OutHeightReset = 13'd40;

  localparam logic [15:0] WeightRed   = 16'd19595;
  localparam logic [15:0] WeightGreen = 16'd38470;
  localparam logic [15:0] WeightBlue  = 16'd7471;

  localparam logic [7:0] Ramp [RampChars] = '{
    8'h20, 8'h2E, 8'h2C, 8'h2D, 8'h3D, 8'h2B, 8'h2A, 8'h23, 8'h25, 8'h40
  };

  typedef struct packed {
    logic [CfgWidth-1:0] src_width;
    logic [CfgWidth-1:0] src_height;
    logic [CfgWidth-1:0] dst_width;
    logic [CfgWidth-1:0] dst_height;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic end_of_row;
    logic end_of_frame;
  } sel_t;

endpackage

`default_nettype wire

[hw/rtl/rtar_sampler.sv]
// Raster counters and nearest-neighbour pixel selection.
`default_nettype none

module rtar_sampler #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rtar_pkg::cfg_t cfg_i,
  input  wire logic          restart_i,
  input  wire logic          step_i,
  input  wire logic          frame_start_i,
  output rtar_pkg::sel_t     sel_o
);
  import rtar_pkg::*;

  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int XW = (DW > CfgWidth) ? DW : CfgWidth;
  localparam int PW = 2 * DW;
  localparam logic [XW-1:0] MaxDim = XW'(MAX_DIMENSION);

  logic [XW-1:0] sw_x, sh_x, ow_x, oh_x;
  logic [DW-1:0] w, h, ow, oh;

  logic [DW-1:0] sc_q, sc_d, sr_q, sr_d, oc_q, oc_d, or_q, or_d;
  logic [PW-1:0] ct_q, ct_d, rt_q, rt_d, cp_q, cp_d, rp_q, rp_d;
  logic          rs_q, rs_d, restart_q, restart_d;

  logic          rst_eff;
  logic [DW-1:0] sc, sr, oc, orow, sc1, sr1, oc1, or2;
  logic [PW-1:0] ct, rt, cp, rp, ct1, rt2, rp1;
  logic          rs, emit;

  always_comb begin
    sw_x = XW'(cfg_i.src_width);
    sh_x = XW'(cfg_i.src_height);
    ow_x = XW'(cfg_i.dst_width);
    oh_x = XW'(cfg_i.dst_height);
    w  = (sw_x == '0) ? DW'(1) : (sw_x > MaxDim) ? DW'(MaxDim) : DW'(sw_x);
    h  = (sh_x == '0) ? DW'(1) : (sh_x > MaxDim) ? DW'(MaxDim) : DW'(sh_x);
    ow = (ow_x == '0) ? DW'(1) : (ow_x > XW'(w)) ? w : DW'(ow_x);
    oh = (oh_x == '0) ? DW'(1) : (oh_x > XW'(h)) ? h : DW'(oh_x);
  end

  always_comb begin
    rst_eff = restart_q | frame_start_i | (sc_q >= w) | (sr_q >= h);
    sc   = rst_eff ? '0 : sc_q;
    sr   = rst_eff ? '0 : sr_q;
    oc   = rst_eff ? '0 : oc_q;
    orow = rst_eff ? '0 : or_q;
    ct   = rst_eff ? '0 : ct_q;
    rt   = rst_eff ? '0 : rt_q;
    cp   = rst_eff ? PW'(ow) : cp_q;
    rp   = rst_eff ? PW'(oh) : rp_q;
    rs   = rst_eff | rs_q;

    emit = rs && (oc < ow) && (cp > ct);
    sel_o.emit         = emit;
    sel_o.end_of_row   = (oc == ow - DW'(1));
    sel_o.end_of_frame = (oc == ow - DW'(1)) && (orow == oh - DW'(1));

    oc1 = emit ? oc + DW'(1) : oc;
    ct1 = emit ? ct + PW'(w) : ct;
    sc1 = sc + DW'(1);
    sr1 = sr + DW'(1);
    or2 = rs ? orow + DW'(1) : orow;
    rt2 = rs ? rt + PW'(h) : rt;
    rp1 = rp + PW'(oh);

    sc_d = sc1;
    sr_d = sr;
    oc_d = oc1;
    or_d = orow;
    ct_d = ct1;
    rt_d = rt;
    cp_d = cp + PW'(ow);
    rp_d = rp;
    rs_d = rs;
    restart_d = 1'b0;

    if (sc1 >= w) begin
      sc_d = '0;
      oc_d = '0;
      ct_d = '0;
      cp_d = PW'(ow);
      if (sr1 >= h) begin
        sr_d = '0;
        or_d = '0;
        rt_d = '0;
        rp_d = PW'(oh);
        rs_d = 1'b1;
      end else begin
        sr_d = sr1;
        or_d = or2;
        rt_d = rt2;
        rp_d = rp1;
        rs_d = (or2 < oh) && (rp1 > rt2);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q      <= '0;
      sr_q      <= '0;
      oc_q      <= '0;
      or_q      <= '0;
      ct_q      <= '0;
      rt_q      <= '0;
      cp_q      <= '0;
      rp_q      <= '0;
      rs_q      <= 1'b1;
      restart_q <= 1'b1;
    end else if (restart_i) begin
      restart_q <= 1'b1;
    end else if (step_i) begin
      sc_q      <= sc_d;
      sr_q      <= sr_d;
      oc_q      <= oc_d;
      or_q      <= or_d;
      ct_q      <= ct_d;
      rt_q      <= rt_d;
      cp_q      <= cp_d;
      rp_q      <= rp_d;
      rs_q      <= rs_d;
      restart_q <= restart_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rgb_to_ascii_ramp_decimator_unit.sv]
// Top level of the RGB to ASCII ramp decimator.
//
// Source pixels enter on the in_ channel in raster order, one item per cycle
// while in_stall_o is low; frame_start_i on the first pixel of a frame
// restarts the counters. A pixel picked by nearest-neighbour decimation gives
// one result item on the out_ channel: its ramp character and end of row /
// end of frame flags. Other pixels give no result.
// A picked pixel is registered in the input stage, then in the result register.
// Throughput: one pixel per cycle while in_stall_o is low. The two register
// stages hold the luma sum (input stage) and the character (result register).
// When out_stall_i is high and a result is valid, the result register holds;
// the input stage still takes items until it holds a result, and then
// in_stall_o rises until space frees.
// Reset clears the pipeline, restores the default geometry (640x480 to
// 80x40) and restarts the frame. Any configuration write also restarts the
// frame; write only while no item is in flight.
`default_nettype none

module rgb_to_ascii_ramp_decimator_unit #(
  parameter int MAX_DIMENSION = 4096,
  parameter int RAMP_LEVELS   = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    red_i,
  input  wire logic [7:0]                    green_i,
  input  wire logic [7:0]                    blue_i,
  input  wire logic                          frame_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [7:0]                         char_code_o,
  output logic                               end_of_row_o,
  output logic                               end_of_frame_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [rtar_pkg::IdxWidth-1:0] cfg_idx_i,
  input  wire logic [rtar_pkg::CfgWidth-1:0] cfg_data_i
);
  import rtar_pkg::*;

  localparam int IW = (RAMP_LEVELS > 1) ? $clog2(RAMP_LEVELS) : 1;
  localparam int LW = $clog2(RAMP_LEVELS + 1);
  localparam int MW = LumaWidth + LW;
  localparam int TW = MW - 16;

  cfg_t cfg_q;
  sel_t sel;

  logic                 accept, out_en;
  logic                 s1_valid_q;
  logic [LumaWidth-1:0] s1_luma_q, luma;
  logic                 s1_eor_q, s1_eof_q;
  logic                 out_valid_q, out_eor_q, out_eof_q;
  logic [7:0]           out_char_q;

  logic [MW-1:0]        scaled;
  logic [TW-1:0]        t;
  logic [TW:0]          q_sum;
  logic [TW-8:0]        q;
  logic [IW-1:0]        idx;
  logic [7:0]           char_lut [RAMP_LEVELS];

  for (genvar k = 0; k < RAMP_LEVELS; k++) begin : g_lut
    localparam int Pos = k * RampChars / RAMP_LEVELS;
    assign char_lut[k] = Ramp[Pos];
  end

  assign out_en     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_en;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= SrcWidthReset;
      cfg_q.src_height <= SrcHeightReset;
      cfg_q.dst_width  <= OutWidthReset;
      cfg_q.dst_height <= OutHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSrcWidth:  cfg_q.src_width  <= cfg_data_i;
        RegSrcHeight: cfg_q.src_height <= cfg_data_i;
        RegOutWidth:  cfg_q.dst_width  <= cfg_data_i;
        RegOutHeight: cfg_q.dst_height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rtar_sampler #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_sampler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .restart_i    (cfg_we_i),
    .step_i       (accept),
    .frame_start_i(frame_start_i),
    .sel_o        (sel)
  );

  assign luma = LumaWidth'(LumaWidth'(red_i) * LumaWidth'(WeightRed))
              + LumaWidth'(LumaWidth'(green_i) * LumaWidth'(WeightGreen))
              + LumaWidth'(LumaWidth'(blue_i) * LumaWidth'(WeightBlue));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= sel.emit;
    end else if (out_en) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_luma_q <= luma;
      s1_eor_q  <= sel.end_of_row;
      s1_eof_q  <= sel.end_of_frame;
    end
  end

  always_comb begin
    scaled = MW'(s1_luma_q) * MW'(RAMP_LEVELS);
    t      = scaled[MW-1:16];
    q_sum  = (TW+1)'(t) + (TW+1)'(t >> 8) + (TW+1)'(1);
    q      = q_sum[TW:8];
    if (q > (TW-7)'(RAMP_LEVELS - 1)) begin
      idx = IW'(RAMP_LEVELS - 1);
    end else begin
      idx = q[IW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_char_q <= char_lut[idx];
      out_eor_q  <= s1_eor_q;
      out_eof_q  <= s1_eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign char_code_o    = out_char_q;
  assign end_of_row_o   = out_eor_q;
  assign end_of_frame_o = out_eof_q;

endmodule

`default_nettype wire

[verif/tb.sv]
// Testbench for rgb_to_ascii_ramp_decimator_unit: pixel stream with decimation predictor.
`timescale 1ns / 100ps

module tb;
  import rtar_pkg::*;

  localparam int MaxDim     = 4096;
  localparam int RampLevels = 10;
  localparam int CycleLimit = 500000;
  localparam int RandomPixels = 750;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0] code;
    logic       eor;
    logic       eof;
  } glyph_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [7:0]          red_i          = '0;
  logic [7:0]          green_i        = '0;
  logic [7:0]          blue_i         = '0;
  logic                frame_start_i  = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [7:0]          char_code_o;
  logic                end_of_row_o;
  logic                end_of_frame_o;
  logic                cfg_we_i       = 1'b0;
  logic [IdxWidth-1:0] cfg_idx_i      = '0;
  logic [CfgWidth-1:0] cfg_data_i     = '0;

  pixel_t pixel_q[$];
  glyph_t glyph_q[$];
  bit     in_taken;
  bit     quiet;
  int     fail_count;
  int     cycle_count;

  logic [12:0] geo_w  = SrcWidthReset;
  logic [12:0] geo_h  = SrcHeightReset;
  logic [12:0] geo_ow = OutWidthReset;
  logic [12:0] geo_oh = OutHeightReset;
  logic [12:0] src_col, src_row, out_col, out_row;
  logic [25:0] col_goal, row_goal;
  logic        row_taken;

  rgb_to_ascii_ramp_decimator_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .char_code_o    (char_code_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_frame_o (end_of_frame_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [12:0] fit_dim(logic [12:0] v, logic [12:0] hi);
    if (v == 13'd0) return 13'd1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] ramp_char(logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b);
    logic [31:0] luma;
    logic [31:0] level;
    luma  = 32'(WeightRed) * r + 32'(WeightGreen) * g + 32'(WeightBlue) * b;
    level = luma * RampLevels / (32'd255 * 32'd65536);
    if (level > RampLevels - 1) level = RampLevels - 1;
    return Ramp[level * RampChars / RampLevels];
  endfunction

  function automatic logic [7:0] rand_channel();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic restart_counters();
    src_col   = '0;
    src_row   = '0;
    out_col   = '0;
    out_row   = '0;
    col_goal  = '0;
    row_goal  = '0;
    row_taken = 1'b1;
  endtask

  task automatic predict_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    logic [12:0] w, h, ow, oh;
    glyph_t      gl;
    w  = fit_dim(geo_w, 13'(MaxDim));
    h  = fit_dim(geo_h, 13'(MaxDim));
    ow = fit_dim(geo_ow, w);
    oh = fit_dim(geo_oh, h);
    if (fs || src_col >= w || src_row >= h) restart_counters();
    if (row_taken && out_col < ow && (26'(src_col) + 26'd1) * 26'(ow) > col_goal) begin
      gl.code = ramp_char(r, g, b);
      gl.eor  = (out_col == ow - 13'd1);
      gl.eof  = gl.eor && (out_row == oh - 13'd1);
      glyph_q.push_back(gl);
      out_col  = out_col + 13'd1;
      col_goal = col_goal + 26'(w);
    end
    src_col = src_col + 13'd1;
    if (src_col >= w) begin
      src_col  = '0;
      out_col  = '0;
      col_goal = '0;
      if (row_taken) begin
        out_row  = out_row + 13'd1;
        row_goal = row_goal + 26'(h);
      end
      src_row = src_row + 13'd1;
      if (src_row >= h) begin
        restart_counters();
      end else begin
        row_taken = (out_row < oh) && ((26'(src_row) + 26'd1) * 26'(oh) > row_goal);
      end
    end
  endtask

  // advance to the next pixel once the current one is taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (rst_ni && pixel_q.size() != 0 && (quiet || $urandom_range(99) >= 17)) begin
        in_valid_i    <= 1'b1;
        red_i         <= pixel_q[0].red;
        green_i       <= pixel_q[0].green;
        blue_i        <= pixel_q[0].blue;
        frame_start_i <= pixel_q[0].frame_start;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= !quiet && ($urandom_range(99) < 17);
  end

  always @(posedge clk_i) begin
    in_taken = in_valid_i && !in_stall_o;
    if (in_taken) begin
      predict_pixel(red_i, green_i, blue_i, frame_start_i);
      void'(pixel_q.pop_front());
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (glyph_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected item char %h eor %b eof %b", $time,
                 char_code_o, end_of_row_o, end_of_frame_o);
      end else begin
        if (glyph_q[0].code !== char_code_o || glyph_q[0].eor !== end_of_row_o ||
            glyph_q[0].eof !== end_of_frame_o) begin
          fail_count++;
          $display("%0t: expected char %h eor %b eof %b, got char %h eor %b eof %b",
                   $time, glyph_q[0].code, glyph_q[0].eor, glyph_q[0].eof,
                   char_code_o, end_of_row_o, end_of_frame_o);
        end
        void'(glyph_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("rgb_to_ascii_ramp_decimator_unit regression: fail");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fs);
    pixel_t px;
    while (pixel_q.size() >= 2) @(negedge clk_i);
    px.red         = r;
    px.green       = g;
    px.blue        = b;
    px.frame_start = fs;
    pixel_q.push_back(px);
  endtask

  task automatic wait_for_results();
    do @(negedge clk_i); while (pixel_q.size() != 0 || glyph_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IdxWidth-1:0] idx, logic [12:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      RegSrcWidth:  geo_w  = val;
      RegSrcHeight: geo_h  = val;
      RegOutWidth:  geo_ow = val;
      RegOutHeight: geo_oh = val;
      default: ;
    endcase
    restart_counters();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_geometry(logic [12:0] w, logic [12:0] h, logic [12:0] ow,
                                logic [12:0] oh);
    wait_for_results();
    write_reg(RegSrcWidth, w);
    write_reg(RegSrcHeight, h);
    write_reg(RegOutWidth, ow);
    write_reg(RegOutHeight, oh);
  endtask

  task automatic test_reset_geometry();
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    for (int i = 1; i < 10; i++) begin
      if (i == 8) send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      else send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
    end
  endtask

  task automatic test_ramp_levels();
    write_geometry(13'd4, 13'd2, 13'd4, 13'd2);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
    send_pixel(8'h80, 8'h80, 8'h80, 1'b0);
    send_pixel(8'h19, 8'h1A, 8'h19, 1'b0);
    send_pixel(8'hFE, 8'hFF, 8'hFF, 1'b0);
    // run past frame end without a frame start, then restart mid-frame
    repeat (3) send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
    send_pixel(8'hAA, 8'h55, 8'hAA, 1'b1);
    repeat (2) send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
  endtask

  task automatic test_degenerate_geometry();
    write_geometry(13'd0, 13'd0, 13'd0, 13'd0);
    repeat (3) send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
    write_geometry(13'd3, 13'd2, 13'd7, 13'd9);
    for (int i = 0; i < 6; i++) begin
      send_pixel(rand_channel(), rand_channel(), rand_channel(), i == 0);
    end
    write_geometry(13'h1FFF, 13'd1, 13'h1FFF, 13'd1);
    for (int i = 0; i < 300; i++) begin
      send_pixel(rand_channel(), rand_channel(), rand_channel(), i == 0);
    end
    write_geometry(13'd1, 13'(MaxDim), 13'd1, 13'd3000);
    for (int i = 0; i < 200; i++) begin
      send_pixel(rand_channel(), rand_channel(), rand_channel(), i == 0);
    end
  endtask

  task automatic test_restart_on_write();
    write_geometry(13'd6, 13'd4, 13'd3, 13'd2);
    for (int i = 0; i < 9; i++) send_pixel(rand_channel(), rand_channel(), rand_channel(), i == 0);
    wait_for_results();
    write_reg(RegOutHeight, 13'd2);
    repeat (24) send_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0);
  endtask

  task automatic test_random_frames();
    int phase;
    int sent;
    int w, h, ow, oh;
    int span;
    int roll;
    phase = 0;
    sent  = 0;
    while (sent < RandomPixels) begin
      quiet = (phase >= 3 && phase < 6);
      if ($urandom_range(7) == 0) begin
        w = $urandom_range(13, 200);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 10);
      end
      case ($urandom_range(7))
        0:       ow = 0;
        1:       ow = w + $urandom_range(1, 5);
        2:       ow = w;
        default: ow = $urandom_range(1, w);
      endcase
      case ($urandom_range(7))
        0:       oh = 0;
        1:       oh = h + $urandom_range(1, 5);
        2:       oh = h;
        default: oh = $urandom_range(1, h);
      endcase
      write_geometry(13'(w), 13'(h), 13'(ow), 13'(oh));
      repeat ($urandom_range(1, 3)) begin
        span = w * h;
        roll = $urandom_range(99);
        if (roll < 10) span = $urandom_range(1, span);
        else if (roll < 15) span = span + $urandom_range(1, w);
        for (int i = 0; i < span; i++) begin
          // hold the stream until the block has caught up
          if (phase == 2 && i == span / 2) wait_for_results();
          send_pixel(rand_channel(), rand_channel(), rand_channel(),
                     (i == 0) || ($urandom_range(99) < 2));
        end
        sent += span;
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    restart_counters();
    @(negedge clk_i);
    test_reset_geometry();
    test_ramp_levels();
    test_degenerate_geometry();
    test_restart_on_write();
    test_random_frames();
    wait_for_results();
    if (fail_count == 0) begin
      $display("rgb_to_ascii_ramp_decimator_unit regression: pass");
    end else begin
      $display("rgb_to_ascii_ramp_decimator_unit regression: fail");
    end
    $finish;
  end

endmodule
